// ===== sv/buddy_heap_allocator_unit_macros.svh =====
// Assertion macros for the RTL of the buddy heap allocator (used by buddy_heap_allocator_unit.sv).
`ifndef BUDDY_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BHA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BHA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BHA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BHA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/bha_pkg.sv =====
package bha_pkg;

    typedef enum logic [1:0] {
        NS_ABSENT = 2'd0,
        NS_FREE   = 2'd1,
        NS_USED   = 2'd2,
        NS_SPLIT  = 2'd3
    } node_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD     = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOBLOCK = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_BACK,
        S_SPLIT0,
        S_SPLIT1,
        S_SPLIT2,
        S_USED,
        S_F_RD,
        S_F_CHK,
        S_F_WR,
        S_M_RDL,
        S_M_CHKL,
        S_M_RDR,
        S_M_CHKR,
        S_M_W0,
        S_M_W1,
        S_M_W2,
        S_DONE
    } state_t;

    localparam logic [0:0] MODE_ALLOC = 1'b0;

endpackage

// ===== sv/buddy_heap_allocator_unit.sv =====
// Buddy heap allocator: manages a heap of MIN_BLOCK_BYTES << MAX_ORDER bytes
// (4096 by default) that starts at the virtual address held in register
// heap_base (byte address 0 of the APB port, reset 16384). An allocate
// transfer (s_tuser = 0) rounds its byte count up to a power-of-two block and
// returns the lowest-addressed free block that fits, splitting larger blocks;
// a free transfer (s_tuser = 1) releases the block starting at the given
// address and merges free buddies upward. Every request gives exactly one
// result transfer. The block handles one request at a time; the node-state
// memory has a single port and the sequencer makes one access per cycle.
// A rejected request (bad size or an address outside the heap) goes straight
// to the result hand-off. An allocate reads and checks each tree node that its
// depth-first search visits, steps back up where a branch has no fit, writes
// three nodes for each level split and then marks the block used. A free reads
// each tree level walked down, marks the leaf, and for each level merged reads
// both buddies and writes them and their parent. No clearing pass is needed
// after reset.
`include "buddy_heap_allocator_unit_macros.svh"
module buddy_heap_allocator_unit #(
    parameter int MIN_BLOCK_BYTES = 32,
    parameter int MAX_ORDER       = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // request_bytes[12:0], block_address[28:13]
    input  logic [0:0]  s_tuser,   // mode[0]
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_address[15:0], block_bytes[28:16]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import bha_pkg::*;

    localparam int HEAP_BYTES = MIN_BLOCK_BYTES << MAX_ORDER;
    localparam int NODE_COUNT = (2 << MAX_ORDER) - 1;
    localparam int IDX_W      = MAX_ORDER + 1;
    localparam int LVL_W      = $clog2(MAX_ORDER + 1);
    localparam int OFF_W      = $clog2(HEAP_BYTES);

    // Configuration register. Only byte address 0 holds a register.
    logic [15:0] heap_base_reg;
    logic [15:0] heap_base_next;

    always_comb begin
        heap_base_next = heap_base_reg;
        if (psel && penable && pwrite && pready && (paddr == 3'd0)) begin
            heap_base_next = pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg <= 16'd16384;
        end else begin
            heap_base_reg <= heap_base_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {16'd0, heap_base_reg} : 32'd0;

    // Sequencer state and working registers.
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [LVL_W-1:0]   tgt_reg, tgt_next;
    logic [OFF_W-1:0]   start_reg, start_next;
    logic [OFF_W:0]     size_reg, size_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    status_t            status_reg, status_next;
    logic [15:0]        raddr_reg, raddr_next;
    logic [12:0]        rbytes_reg, rbytes_next;
    logic               m_valid_reg, m_valid_next;
    logic [31:0]        m_data_reg, m_data_next;
    logic [1:0]         m_user_reg, m_user_next;

    // Node-state memory port.
    logic               mem_we;
    logic [IDX_W-1:0]   mem_addr;
    node_t              mem_wdata;
    node_t              mem_rdata;

    bha_node_mem #(
        .DEPTH  (NODE_COUNT),
        .ADDR_W (IDX_W)
    ) u_node_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (mem_we),
        .addr    (mem_addr),
        .wdata   (mem_wdata),
        .rdata   (mem_rdata)
    );

    // Tree navigation around the current node.
    logic [IDX_W-1:0] left_idx, right_idx, parent_idx, sib_left, sib_right;
    assign left_idx   = {idx_reg[IDX_W-2:0], 1'b1};
    assign right_idx  = left_idx + IDX_W'(1);
    assign parent_idx = (idx_reg - IDX_W'(1)) >> 1;
    assign sib_left   = idx_reg[0] ? idx_reg : idx_reg - IDX_W'(1);
    assign sib_right  = sib_left + IDX_W'(1);

    // Request decode, used at acceptance.
    logic        req_mode;
    logic [12:0] req_bytes;
    logic [15:0] req_addr;
    logic [LVL_W-1:0] k_cnt;
    logic [31:0] blk_bytes;
    logic        size_bad;
    logic        addr_bad;
    logic [31:0] heap_end;
    logic [15:0] off_full;

    assign req_mode  = s_tuser[0];
    assign req_bytes = s_tdata[12:0];
    assign req_addr  = s_tdata[28:13];

    // The order is the number of block sizes below the request.
    always_comb begin
        k_cnt = '0;
        for (int j = 0; j < MAX_ORDER; j++) begin
            if ((32'(MIN_BLOCK_BYTES) << j) < {19'd0, req_bytes}) begin
                k_cnt = k_cnt + LVL_W'(1);
            end
        end
    end

    assign blk_bytes = 32'(MIN_BLOCK_BYTES) << k_cnt;
    assign size_bad  = (req_bytes == 13'd0) || ({19'd0, req_bytes} > 32'(HEAP_BYTES));
    assign heap_end  = {16'd0, heap_base_reg} + 32'(HEAP_BYTES);
    assign addr_bad  = (req_addr < heap_base_reg) || ({16'd0, req_addr} >= heap_end);
    assign off_full  = req_addr - heap_base_reg;

    logic [OFF_W:0]  half_size;
    logic [OFF_W:0]  mid_point;
    logic [31:0]     size_wide;
    logic [31:0]     alloc_addr;
    assign half_size  = size_reg >> 1;
    assign mid_point  = {1'b0, start_reg} + half_size;
    assign size_wide  = 32'(size_reg);
    assign alloc_addr = {16'd0, heap_base_reg} + 32'(start_reg);

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (req_mode == MODE_ALLOC) begin
                        state_next = size_bad ? S_DONE : S_A_RD;
                    end else begin
                        state_next = addr_bad ? S_DONE : S_F_RD;
                    end
                end
            end
            S_A_RD:   state_next = S_A_CHK;
            S_A_CHK: begin
                if (mem_rdata == NS_FREE) begin
                    state_next = (lvl_reg < tgt_reg) ? S_SPLIT0 : S_USED;
                end else if (mem_rdata == NS_SPLIT && lvl_reg < tgt_reg) begin
                    state_next = S_A_RD;
                end else begin
                    state_next = S_BACK;
                end
            end
            S_BACK: begin
                if (idx_reg == '0) begin
                    state_next = S_DONE;
                end else if (idx_reg[0]) begin
                    state_next = S_A_RD;
                end
            end
            S_SPLIT0: state_next = S_SPLIT1;
            S_SPLIT1: state_next = S_SPLIT2;
            S_SPLIT2: state_next = (lvl_reg + LVL_W'(1) < tgt_reg) ? S_SPLIT0 : S_USED;
            S_USED:   state_next = S_DONE;
            S_F_RD:   state_next = S_F_CHK;
            S_F_CHK: begin
                if (mem_rdata == NS_SPLIT) begin
                    state_next = (lvl_reg == LVL_W'(MAX_ORDER)) ? S_DONE : S_F_RD;
                end else if (mem_rdata == NS_ABSENT || start_reg != off_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_F_WR;
                end
            end
            S_F_WR:   state_next = (idx_reg == '0) ? S_DONE : S_M_RDL;
            S_M_RDL:  state_next = S_M_CHKL;
            S_M_CHKL: state_next = (mem_rdata == NS_FREE) ? S_M_RDR : S_DONE;
            S_M_RDR:  state_next = S_M_CHKR;
            S_M_CHKR: state_next = (mem_rdata == NS_FREE) ? S_M_W0 : S_DONE;
            S_M_W0:   state_next = S_M_W1;
            S_M_W1:   state_next = S_M_W2;
            S_M_W2:   state_next = (parent_idx == '0) ? S_DONE : S_M_RDL;
            S_DONE:   state_next = out_free ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Memory port control.
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = idx_reg;
        mem_wdata = NS_ABSENT;
        unique case (state_reg)
            S_SPLIT0: begin
                mem_we    = 1'b1;
                mem_wdata = NS_SPLIT;
            end
            S_SPLIT1: begin
                mem_we    = 1'b1;
                mem_addr  = left_idx;
                mem_wdata = NS_FREE;
            end
            S_SPLIT2: begin
                mem_we    = 1'b1;
                mem_addr  = right_idx;
                mem_wdata = NS_FREE;
            end
            S_USED: begin
                mem_we    = 1'b1;
                mem_wdata = NS_USED;
            end
            S_F_WR: begin
                mem_we    = 1'b1;
                mem_wdata = NS_FREE;
            end
            S_M_RDL:  mem_addr = sib_left;
            S_M_RDR:  mem_addr = sib_right;
            S_M_W0: begin
                mem_we    = 1'b1;
                mem_addr  = sib_left;
                mem_wdata = NS_ABSENT;
            end
            S_M_W1: begin
                mem_we    = 1'b1;
                mem_addr  = sib_right;
                mem_wdata = NS_ABSENT;
            end
            S_M_W2: begin
                mem_we    = 1'b1;
                mem_addr  = parent_idx;
                mem_wdata = NS_FREE;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        idx_next     = idx_reg;
        lvl_next     = lvl_reg;
        tgt_next     = tgt_reg;
        start_next   = start_reg;
        size_next    = size_reg;
        off_next     = off_reg;
        status_next  = status_reg;
        raddr_next   = raddr_reg;
        rbytes_next  = rbytes_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                idx_next    = '0;
                lvl_next    = '0;
                start_next  = '0;
                size_next   = (OFF_W + 1)'(HEAP_BYTES);
                status_next = ST_OK;
                raddr_next  = 16'd0;
                rbytes_next = 13'd0;
                tgt_next    = LVL_W'(MAX_ORDER) - k_cnt;
                off_next    = off_full[OFF_W-1:0];
                if (req_mode == MODE_ALLOC) begin
                    if (size_bad) begin
                        status_next = ST_BAD;
                    end else begin
                        rbytes_next = blk_bytes[12:0];
                    end
                end else if (addr_bad) begin
                    status_next = ST_BAD;
                end
            end
            S_A_CHK: begin
                if (mem_rdata == NS_SPLIT && lvl_reg < tgt_reg && mem_rdata != NS_FREE) begin
                    idx_next  = left_idx;
                    lvl_next  = lvl_reg + LVL_W'(1);
                    size_next = half_size;
                end
            end
            S_BACK: begin
                if (idx_reg == '0) begin
                    status_next = ST_FULL;
                    rbytes_next = 13'd0;
                end else if (idx_reg[0]) begin
                    idx_next   = idx_reg + IDX_W'(1);
                    start_next = start_reg + size_reg[OFF_W-1:0];
                end else begin
                    idx_next   = parent_idx;
                    lvl_next   = lvl_reg - LVL_W'(1);
                    start_next = start_reg - size_reg[OFF_W-1:0];
                    size_next  = size_reg << 1;
                end
            end
            S_SPLIT2: begin
                idx_next  = left_idx;
                lvl_next  = lvl_reg + LVL_W'(1);
                size_next = half_size;
            end
            S_USED: begin
                raddr_next = alloc_addr[15:0];
            end
            S_F_CHK: begin
                if (mem_rdata == NS_SPLIT) begin
                    if (lvl_reg == LVL_W'(MAX_ORDER)) begin
                        status_next = ST_NOBLOCK;
                    end else begin
                        lvl_next  = lvl_reg + LVL_W'(1);
                        size_next = half_size;
                        if ({1'b0, off_reg} >= mid_point) begin
                            start_next = mid_point[OFF_W-1:0];
                            idx_next   = right_idx;
                        end else begin
                            idx_next   = left_idx;
                        end
                    end
                end else if (mem_rdata == NS_ABSENT || start_reg != off_reg) begin
                    status_next = ST_NOBLOCK;
                end else begin
                    rbytes_next = size_wide[12:0];
                end
            end
            S_M_W2: begin
                idx_next = parent_idx;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_user_next  = status_reg;
                    m_data_next  = {3'd0, rbytes_reg, raddr_reg};
                end
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        lvl_reg    <= lvl_next;
        tgt_reg    <= tgt_next;
        start_reg  <= start_next;
        size_reg   <= size_next;
        off_reg    <= off_next;
        status_reg <= status_next;
        raddr_reg  <= raddr_next;
        rbytes_reg <= rbytes_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // A request keeps the block busy for at least the cycle after it is taken.
    `BHA_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // Every failed request reports a zero address and a zero size.
    `BHA_ASSERT_IMP(a_error_zero, aclk, aresetn, m_tvalid && (m_tuser != 2'(ST_OK)), m_tdata == 32'd0)
    // A result appears only from the hand-off state of the sequencer.
    `BHA_ASSERT_IMP(a_result_from_done, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == S_DONE))

endmodule

// ===== sv/bha_node_mem.sv =====
module bha_node_mem #(
    parameter int DEPTH  = 255,
    parameter int ADDR_W = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                we,
    input  logic [ADDR_W-1:0]   addr,
    input  bha_pkg::node_t      wdata,
    output bha_pkg::node_t      rdata
);
    import bha_pkg::*;

    node_t              mem [DEPTH];
    logic [DEPTH-1:0]   vld_reg;
    logic [DEPTH-1:0]   vld_next;
    node_t              rdata_reg;

    // An entry never written reads as its reset value: the root is a free leaf.
    always_comb begin
        vld_next = vld_reg;
        if (we) begin
            vld_next[addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (vld_reg[addr]) begin
            rdata_reg <= mem[addr];
        end else if (addr == '0) begin
            rdata_reg <= NS_FREE;
        end else begin
            rdata_reg <= NS_ABSENT;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/sv/tb_buddy_heap_allocator_unit.sv =====
module tb_buddy_heap_allocator_unit;
    import bha_pkg::*;

    localparam int MIN_BYTES  = 32;
    localparam int TOP_ORDER  = 7;
    localparam int HEAP_SIZE  = MIN_BYTES << TOP_ORDER;
    localparam int TREE_NODES = (2 << TOP_ORDER) - 1;
    localparam logic [2:0] REG_HEAP_BASE = 3'd0;
    localparam logic [0:0] MODE_FREE = 1'b1;

    // One result transfer as the block reports it.
    typedef struct packed {
        status_t     status;
        logic [15:0] addr;
        logic [12:0] bytes;
    } alloc_result_t;

    // The scoreboard keeps its own copy of the buddy tree and the heap base,
    // predicts one result per accepted request and checks results in order.
    class heap_scoreboard;
        node_t         tree[TREE_NODES];
        logic [15:0]   base;
        alloc_result_t pending[$];
        int            errors;
        int            checked;
        int            n_ok, n_bad, n_full, n_noblock;

        function void clear_tree();
            foreach (tree[i]) tree[i] = NS_ABSENT;
            tree[0] = NS_FREE;
            base = 16'd16384;
        endfunction

        // Depth-first, lower half first; returns node index or -1.
        function int find_free(int idx, int lvl, int tgt, int start, int size,
                               output int lvl_o, output int start_o);
            int r;
            if (idx >= TREE_NODES || lvl > tgt) return -1;
            if (tree[idx] == NS_FREE) begin
                lvl_o = lvl;
                start_o = start;
                return idx;
            end
            if (tree[idx] != NS_SPLIT || lvl >= tgt) return -1;
            r = find_free(2*idx+1, lvl+1, tgt, start, size/2, lvl_o, start_o);
            if (r < 0)
                r = find_free(2*idx+2, lvl+1, tgt, start+size/2, size/2, lvl_o, start_o);
            return r;
        endfunction

        function void note_request(logic mode, logic [12:0] req, logic [15:0] va);
            alloc_result_t res;
            int k, tgt, lvl, start, idx, off, size, parent;
            res = '{ST_OK, 16'd0, 13'd0};
            if (mode != MODE_FREE) begin
                if (req == 0 || req > HEAP_SIZE) begin
                    res.status = ST_BAD;
                end else begin
                    k = 0;
                    while (k < TOP_ORDER && (MIN_BYTES << k) < req) k++;
                    tgt = TOP_ORDER - k;
                    idx = find_free(0, 0, tgt, 0, HEAP_SIZE, lvl, start);
                    if (idx < 0) begin
                        res.status = ST_FULL;
                    end else begin
                        while (lvl < tgt) begin
                            tree[idx] = NS_SPLIT;
                            tree[2*idx+1] = NS_FREE;
                            tree[2*idx+2] = NS_FREE;
                            idx = 2*idx+1;
                            lvl++;
                        end
                        tree[idx] = NS_USED;
                        res.addr = base + 16'(start);
                        res.bytes = 13'(MIN_BYTES << k);
                    end
                end
            end else if (int'(va) < int'(base) || int'(va) >= int'(base) + HEAP_SIZE) begin
                res.status = ST_BAD;
            end else begin
                off = int'(va) - int'(base);
                idx = 0;
                start = 0;
                size = HEAP_SIZE;
                while (idx < TREE_NODES && tree[idx] == NS_SPLIT) begin
                    size = size / 2;
                    if (off >= start + size) begin
                        start += size;
                        idx = 2*idx+2;
                    end else begin
                        idx = 2*idx+1;
                    end
                end
                if (idx >= TREE_NODES || tree[idx] == NS_ABSENT || start != off) begin
                    res.status = ST_NOBLOCK;
                end else begin
                    tree[idx] = NS_FREE;
                    res.bytes = 13'(size);
                    // Merge buddies upward while both halves are free leaves.
                    while (idx > 0) begin
                        parent = (idx - 1) / 2;
                        if (tree[2*parent+1] != NS_FREE || tree[2*parent+2] != NS_FREE) break;
                        tree[2*parent+1] = NS_ABSENT;
                        tree[2*parent+2] = NS_ABSENT;
                        tree[parent] = NS_FREE;
                        idx = parent;
                    end
                end
            end
            pending.push_back(res);
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t want;
            if (pending.size() == 0) begin
                $error("result transfer with no request outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            case (want.status)
                ST_OK: n_ok++;
                ST_BAD: n_bad++;
                ST_FULL: n_full++;
                default: n_noblock++;
            endcase
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.addr !== want.addr) begin
                $error("result_address: expected %h, got %h", want.addr, got.addr);
                errors++;
            end
            if (got.bytes !== want.bytes) begin
                $error("block_bytes: expected %0d, got %0d", want.bytes, got.bytes);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid, s_tready;
    logic [31:0] s_tdata;   // request_bytes[12:0], block_address[28:13]
    logic [0:0]  s_tuser;   // mode[0]
    logic        m_tvalid, m_tready;
    logic [31:0] m_tdata;   // result_address[15:0], block_bytes[28:16]
    logic [1:0]  m_tuser;   // status[1:0]

    buddy_heap_allocator_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    heap_scoreboard sb;
    int  send_idle_pct;    // chance in percent that the sender idles a cycle
    int  recv_stall_pct;   // chance in percent that the receiver stalls a cycle
    bit  run_done;
    int  n_alloc, n_free;

    // Live allocations, kept so that most frees name a real block.
    logic [15:0] live_blocks[$];

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // A long fixed limit; the slowest correct run is far shorter than this.
    initial begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: the ready line is redrawn on every falling edge, and
    // transfers are taken at the rising edge.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result('{status_t'(m_tuser), m_tdata[15:0], m_tdata[28:16]});
    end

    // APB write with a setup and an access phase; the register takes the value in the access cycle.
    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= addr; pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == REG_HEAP_BASE) sb.base = value[15:0];
    endtask

    // Sends one request transfer on a later falling edge, idling first at the
    // sender's chosen rate.
    task automatic send_request(logic mode, logic [12:0] req, logic [15:0] va);
        do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {3'b000, va, req};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(mode, req, va);
        if (mode == MODE_FREE) n_free++; else n_alloc++;
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Waits until every expected result is back, plus a short settle time.
    task automatic wait_drained();
        int guard;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 200_000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (400) @(negedge aclk);
    endtask

    // Allocation sizes: mostly across all orders, sometimes exact powers.
    function automatic logic [12:0] pick_size();
        int order;
        order = $urandom_range(TOP_ORDER);
        if ($urandom_range(3) == 0) return 13'(MIN_BYTES << order);
        return 13'($urandom_range(MIN_BYTES << order, 1));
    endfunction

    task automatic random_alloc();
        logic [12:0] req;
        req = pick_size();
        send_request(1'b0, req, 16'($urandom));
        // Read what the prediction says so later frees can aim at the block.
        if (sb.pending[sb.pending.size()-1].status == ST_OK)
            live_blocks.push_back(sb.pending[sb.pending.size()-1].addr);
    endtask

    task automatic random_free();
        int pick;
        logic [15:0] va;
        if (live_blocks.size() != 0 && $urandom_range(9) < 7) begin
            pick = $urandom_range(live_blocks.size() - 1);
            va = live_blocks[pick];
            live_blocks.delete(pick);
        end else begin
            case ($urandom_range(3))
                0: va = 16'($urandom);
                1: va = sb.base + 16'($urandom_range(HEAP_SIZE - 1));
                2: va = sb.base + 16'($urandom_range(HEAP_SIZE / MIN_BYTES - 1) * MIN_BYTES);
                default: va = sb.base + 16'(HEAP_SIZE - 1 + $urandom_range(1));
            endcase
        end
        send_request(MODE_FREE, 13'($urandom), va);
    endtask

    task automatic random_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            if ($urandom_range(99) < 50 + (live_blocks.size() < 4 ? 20 : -10))
                random_alloc();
            else
                random_free();
        end
    endtask

    initial begin
        logic [15:0] bases[4];
        sb = new();
        sb.clear_tree();
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        send_idle_pct = 0; recv_stall_pct = 0;
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part at the reset base: bad sizes, each order, exhaustion,
        // frees at the boundaries, mid-block, double free and ignored fields.
        send_request(1'b0, 13'd0, 16'hFFFF);
        send_request(1'b0, 13'd4097, 16'd0);
        send_request(1'b0, 13'h1FFF, 16'd0);
        send_request(1'b0, 13'd1, 16'hFFFF);           // smallest block
        send_request(1'b0, 13'd33, 16'd0);
        send_request(1'b0, 13'd4096, 16'd0);           // heap is not whole: full
        send_request(MODE_FREE, 13'h1FFF, 16'd16384);  // free first block
        send_request(MODE_FREE, 13'd0, 16'd16384);      // double free
        send_request(MODE_FREE, 13'd0, 16'd16384 + 16'd64); // free the 64-byte one
        send_request(1'b0, 13'd4096, 16'd0);           // whole heap after merging
        send_request(1'b0, 13'd1, 16'd0);              // full
        send_request(MODE_FREE, 13'd0, 16'd16384 + 16'd32); // inside a leaf
        send_request(MODE_FREE, 13'd0, 16'd16383);      // below the heap
        send_request(MODE_FREE, 13'd0, 16'd20480);      // just past the heap
        send_request(MODE_FREE, 13'd0, 16'd20479);      // inside, not a start
        send_request(MODE_FREE, 13'd0, 16'd16384);
        send_request(1'b0, 13'd2048, 16'd0);
        send_request(1'b0, 13'd1024, 16'd0);
        send_request(1'b0, 13'd512, 16'd0);
        send_request(1'b0, 13'd256, 16'd0);
        send_request(1'b0, 13'd128, 16'd0);
        send_request(1'b0, 13'd64, 16'd0);
        send_request(1'b0, 13'd32, 16'd0);
        send_request(1'b0, 13'd32, 16'd0);
        wait_drained();

        // Each phase starts from a known heap: a new base, but nothing is freed,
        // since freeing the whole heap at its start works only when it is one leaf;
        // the scoreboard tracks leftovers in its own tree, and the live list restarts.
        bases = '{16'h0000, 16'hF800, 16'hFFFF, 16'h4000};
        live_blocks.delete();
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_HEAP_BASE, {$urandom} ^ {16'($urandom), 16'h0} | 32'(bases[ph]));
            // Keep the upper bits random but the base as chosen.
            write_reg(REG_HEAP_BASE, {16'($urandom), bases[ph]});
            live_blocks.delete();
            case (ph)
                0: random_phase(220, 0, 0);
                1: random_phase(220, 46, 0);
                2: random_phase(220, 0, 46);
                default: random_phase(220, 14, 14);
            endcase
            wait_drained();
        end
        write_reg(REG_HEAP_BASE, {16'($urandom), 16'($urandom)});
        live_blocks.delete();
        random_phase(60, 0, 0);
        wait_drained();

        $display("Sent %0d allocate and %0d free requests over five heap bases;",
                 n_alloc, n_free);
        $display("results: %0d ok, %0d bad, %0d full, %0d not a block.",
                 sb.n_ok, sb.n_bad, sb.n_full, sb.n_noblock);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
